FILE: design/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int CLASS_W     = 4;
	localparam int KIND_W      = 2;
	localparam int WORD_BYTES  = 4;
	localparam int POS_W       = 2;

	// header word is complete once this byte position is taken
	localparam logic [POS_W-1:0] LAST_BYTE_POS = POS_W'(WORD_BYTES - 1);
	// statuses above this value fold into the unknown class
	localparam logic [WORD_W-1:0]  STATUS_MAX     = WORD_W'(7);
	localparam logic [CLASS_W-1:0] STATUS_UNKNOWN = CLASS_W'(8);

	typedef enum logic [1:0] {
		PH_COUNT,
		PH_STATUS,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_BODY,
		KIND_EMPTY_REC,
		KIND_EMPTY_BATCH,
		KIND_TRUNC
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [WORD_W-1:0]   record_index;
		logic [CLASS_W-1:0]  status_class;
		logic [BYTE_W-1:0]   body_byte;
		logic                last_of_record;
		logic                last_of_batch;
	} result_t;

endpackage

`default_nettype wire

FILE: design/rbd_in_if.sv
`default_nettype none

interface rbd_in_if;
	import rbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              stream_end;

	modport source (output valid, output rx_byte, output stream_end, input ready);
	modport sink   (input valid, input rx_byte, input stream_end, output ready);

endinterface

`default_nettype wire

FILE: design/rbd_out_if.sv
`default_nettype none

interface rbd_out_if;
	import rbd_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [WORD_W-1:0]  record_index;
	logic [CLASS_W-1:0] status_class;
	logic [BYTE_W-1:0]  body_byte;
	logic               last_of_record;
	logic               last_of_batch;

	modport source (
		output valid, output kind, output record_index, output status_class,
		output body_byte, output last_of_record, output last_of_batch,
		input ready
	);
	modport sink (
		input valid, input kind, input record_index, input status_class,
		input body_byte, input last_of_record, input last_of_batch,
		output ready
	);

endinterface

`default_nettype wire

FILE: design/rbd_core.sv
`default_nettype none

module rbd_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     take,
	input  wire logic [rbd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                     stream_end,
	output logic                          has_result,
	output rbd_pkg::result_t              result
);
	import rbd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [WORD_W-9:0]   shift_q, shift_d;
	logic [WORD_W-1:0]   expected_q, expected_d;
	logic [WORD_W-1:0]   record_q, record_d;
	logic [CLASS_W-1:0]  status_q, status_d;
	logic [WORD_W-1:0]   remaining_q, remaining_d;

	logic [WORD_W-1:0]   word;
	logic                word_done;
	logic                last_record;
	logic                body_last;

	assign word        = {shift_q, rx_byte};
	assign word_done   = (pos_q == LAST_BYTE_POS);
	assign last_record = (record_q == expected_q - WORD_W'(1));
	assign body_last   = (remaining_q == WORD_W'(1));

	// next state
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		shift_d     = shift_q;
		expected_d  = expected_q;
		record_d    = record_q;
		status_d    = status_q;
		remaining_d = remaining_q;
		if (stream_end) begin
			phase_d     = PH_COUNT;
			pos_d       = '0;
			shift_d     = '0;
			expected_d  = '0;
			record_d    = '0;
			status_d    = '0;
			remaining_d = '0;
		end else if (phase_q == PH_BODY) begin
			remaining_d = remaining_q - WORD_W'(1);
			if (body_last) begin
				if (last_record) begin
					phase_d    = PH_COUNT;
					expected_d = '0;
					record_d   = '0;
				end else begin
					phase_d  = PH_STATUS;
					record_d = record_q + WORD_W'(1);
				end
				status_d = '0;
			end
		end else if (!word_done) begin
			pos_d   = pos_q + POS_W'(1);
			shift_d = word[WORD_W-9:0];
		end else begin
			pos_d   = '0;
			shift_d = '0;
			unique case (phase_q)
				PH_COUNT: begin
					// a zero count leaves everything at the header
					if (word != '0) begin
						expected_d = word;
						record_d   = '0;
						status_d   = '0;
						phase_d    = PH_STATUS;
					end
				end
				PH_STATUS: begin
					status_d = (word > STATUS_MAX) ? STATUS_UNKNOWN : word[CLASS_W-1:0];
					phase_d  = PH_LENGTH;
				end
				PH_LENGTH: begin
					if (word == '0) begin
						status_d = '0;
						if (last_record) begin
							phase_d    = PH_COUNT;
							expected_d = '0;
							record_d   = '0;
						end else begin
							phase_d  = PH_STATUS;
							record_d = record_q + WORD_W'(1);
						end
					end else begin
						remaining_d = word;
						phase_d     = PH_BODY;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result of the current item
	always_comb begin
		has_result            = 1'b0;
		result.kind           = KIND_BODY;
		result.record_index   = record_q;
		result.status_class   = status_q;
		result.body_byte      = '0;
		result.last_of_record = 1'b0;
		result.last_of_batch  = 1'b0;
		if (stream_end) begin
			// close at an untouched header is silent
			has_result           = !(phase_q == PH_COUNT && pos_q == '0);
			result.kind          = KIND_TRUNC;
			result.last_of_batch = 1'b1;
		end else if (phase_q == PH_BODY) begin
			has_result            = 1'b1;
			result.body_byte      = rx_byte;
			result.last_of_record = body_last;
			result.last_of_batch  = body_last && last_record;
		end else if (word_done && word == '0) begin
			if (phase_q == PH_COUNT) begin
				has_result           = 1'b1;
				result.kind          = KIND_EMPTY_BATCH;
				result.record_index  = '0;
				result.status_class  = '0;
				result.last_of_batch = 1'b1;
			end else if (phase_q == PH_LENGTH) begin
				has_result            = 1'b1;
				result.kind           = KIND_EMPTY_REC;
				result.last_of_record = 1'b1;
				result.last_of_batch  = last_record;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			pos_q       <= '0;
			shift_q     <= '0;
			expected_q  <= '0;
			record_q    <= '0;
			status_q    <= '0;
			remaining_q <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			shift_q     <= shift_d;
			expected_q  <= expected_d;
			record_q    <= record_d;
			status_q    <= status_d;
			remaining_q <= remaining_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/reply_batch_deframer_top.sv
// channel | dir | payload                                           | role
// --------+-----+---------------------------------------------------+---------------------
// rx      | in  | rx_byte, stream_end                               | reply byte stream
// res     | out | kind, record_index, status_class, body_byte,      | tagged body bytes
//         |     | last_of_record, last_of_batch                     | and record events
//
// One byte per cycle while res is not stalled: the header counters and the result
// are computed in the same cycle the byte is taken; the result lands in a single
// output register, so res.valid rises in the cycle after a byte that yields one.
// arst_n returns the deframer to the count header; no clearing pass is needed.
// A stalled res holds its register; rx stays ready while that register drains.
`default_nettype none

module reply_batch_deframer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	rbd_in_if.sink    rx,
	rbd_out_if.source res
);
	import rbd_pkg::*;

	logic    take;
	logic    has_result;
	result_t result;
	logic    res_valid_q;
	result_t res_q;

	// accept while the output register is empty or draining this cycle
	assign rx.ready = !res_valid_q || res.ready;
	assign take     = rx.valid && rx.ready;

	rbd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx.rx_byte),
		.stream_end (rx.stream_end),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= has_result;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			res_q <= result;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.kind           = res_q.kind;
	assign res.record_index   = res_q.record_index;
	assign res.status_class   = res_q.status_class;
	assign res.body_byte      = res_q.body_byte;
	assign res.last_of_record = res_q.last_of_record;
	assign res.last_of_batch  = res_q.last_of_batch;

endmodule

`default_nettype wire

FILE: verif/reply_batch_deframer_top_tb.sv
module reply_batch_deframer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rbd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;

	rbd_in_if  rx_ch ();
	rbd_out_if res_ch ();

	reply_batch_deframer_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	// deframer state as the testbench tracks it
	phase_t             ph;
	logic [POS_W-1:0]   pos;
	logic [WORD_W-1:0]  shift_word;
	logic [WORD_W-1:0]  rec_total;
	logic [WORD_W-1:0]  rec_cur;
	logic [CLASS_W-1:0] cls_cur;
	logic [WORD_W-1:0]  body_left;

	result_t results_due[$];

	bit calm;
	int bytes_sent;
	int results_seen;
	int mismatches;
	int kinds_seen[4];
	int cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run stopped after %0d cycles, %0d results still due", $time,
				cycles, results_due.size());
			$display("reply_batch_deframer_top: mismatch");
			$finish;
		end
	end

	function automatic void clear_state();
		ph         = PH_COUNT;
		pos        = '0;
		shift_word = '0;
		rec_total  = '0;
		rec_cur    = '0;
		cls_cur    = '0;
		body_left  = '0;
	endfunction

	// advance to the next record; return 1 when the batch is done
	function automatic logic close_record();
		logic done;
		done = (rec_cur == rec_total - 32'd1);
		if (done) begin
			clear_state();
		end else begin
			rec_cur = rec_cur + 32'd1;
			cls_cur = '0;
			ph      = PH_STATUS;
		end
		return done;
	endfunction

	task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic closed);
		result_t           r;
		logic [WORD_W-1:0] word;
		r = '0;
		if (closed) begin
			if (!(ph == PH_COUNT && pos == '0)) begin
				r.kind          = KIND_TRUNC;
				r.record_index  = rec_cur;
				r.status_class  = cls_cur;
				r.last_of_batch = 1'b1;
				results_due.push_back(r);
			end
			clear_state();
			return;
		end
		if (ph == PH_BODY) begin
			r.kind         = KIND_BODY;
			r.record_index = rec_cur;
			r.status_class = cls_cur;
			r.body_byte    = b;
			body_left      = body_left - 32'd1;
			if (body_left == '0) begin
				r.last_of_record = 1'b1;
				r.last_of_batch  = close_record();
			end
			results_due.push_back(r);
			return;
		end
		shift_word = {shift_word[WORD_W-BYTE_W-1:0], b};
		if (pos != LAST_BYTE_POS) begin
			pos = pos + 1'b1;
			return;
		end
		word       = shift_word;
		pos        = '0;
		shift_word = '0;
		case (ph)
			PH_COUNT: begin
				if (word == '0) begin
					clear_state();
					r.kind          = KIND_EMPTY_BATCH;
					r.last_of_batch = 1'b1;
					results_due.push_back(r);
				end else begin
					rec_total = word;
					rec_cur   = '0;
					cls_cur   = '0;
					ph        = PH_STATUS;
				end
			end
			PH_STATUS: begin
				cls_cur = (word > STATUS_MAX) ? STATUS_UNKNOWN : CLASS_W'(word);
				ph      = PH_LENGTH;
			end
			default: begin
				if (word == '0) begin
					r.kind           = KIND_EMPTY_REC;
					r.record_index   = rec_cur;
					r.status_class   = cls_cur;
					r.last_of_record = 1'b1;
					r.last_of_batch  = close_record();
					results_due.push_back(r);
				end else begin
					body_left = word;
					ph        = PH_BODY;
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called and returns at a falling edge
	task automatic send_rx(input logic [BYTE_W-1:0] b, input logic closed);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid      <= 1'b1;
		rx_ch.rx_byte    <= b;
		rx_ch.stream_end <= closed;
		do @(posedge clk); while (!rx_ch.ready);
		deframe_byte(b, closed);
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic void put_word(ref logic [BYTE_W-1:0] q[$], input logic [WORD_W-1:0] w);
		q.push_back(w[31:24]);
		q.push_back(w[23:16]);
		q.push_back(w[15:8]);
		q.push_back(w[7:0]);
	endfunction

	function automatic logic [WORD_W-1:0] pick_status();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, 7);
		if (r == 6) return 32'd8;
		if (r == 7) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 0;
		if (r < 8) return $urandom_range(1, 6);
		if (r < 9) return $urandom_range(7, 20);
		return $urandom_range(21, 60);
	endfunction

	// one batch with random content; cut_pct is the chance of a close inside it
	task automatic send_batch(input int cut_pct);
		logic [BYTE_W-1:0] frame[$];
		logic [WORD_W-1:0] count;
		int                n_rec;
		int                len;
		int                cut;
		bit                overcount;
		n_rec     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		overcount = ($urandom_range(0, 9) == 0);
		count     = n_rec;
		if (overcount)
			count = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : n_rec + $urandom_range(1, 3);
		put_word(frame, count);
		for (int k = 0; k < n_rec; k++) begin
			len = pick_len();
			put_word(frame, pick_status());
			put_word(frame, len);
			repeat (len) frame.push_back(BYTE_W'($urandom));
		end
		cut = ($urandom_range(0, 99) < cut_pct) ? $urandom_range(0, frame.size() - 1) : -1;
		foreach (frame[i]) begin
			if (i == cut) begin
				send_rx(BYTE_W'($urandom), 1'b1);
				return;
			end
			send_rx(frame[i], 1'b0);
		end
		// a count larger than the records sent needs a close to end it
		if (overcount || $urandom_range(0, 9) == 0)
			send_rx(BYTE_W'($urandom), 1'b1);
	endtask

	task automatic test_directed();
		send_rx(8'h3C, 1'b1);
		repeat (4) send_rx(8'h00, 1'b0);
		repeat (3) send_rx(8'h00, 1'b0);
		send_rx(8'h01, 1'b0);
		repeat (4) send_rx(8'hFF, 1'b0);
		repeat (4) send_rx(8'h00, 1'b0);
		repeat (2) send_rx(8'h00, 1'b0);
		send_rx(8'hA5, 1'b1);
	endtask

	task automatic test_framed_batches();
		calm = 1'b0;
		while (bytes_sent < 920) send_batch(15);
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		while (bytes_sent < 1170) send_batch(10);
		calm = 1'b0;
	endtask

	task automatic test_cut_and_noise();
		int burst;
		while (bytes_sent < 1450) begin
			if ($urandom_range(0, 1) == 0) begin
				burst = $urandom_range(1, 30);
				repeat (burst) send_rx(BYTE_W'($urandom), ($urandom_range(0, 11) == 0));
				send_rx(BYTE_W'($urandom), 1'b1);
			end else begin
				send_batch(100);
			end
		end
	endtask

	initial begin
		int hold;
		hold         = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				hold = pick_gap();
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind           = kind_t'(res_ch.kind);
			got.record_index   = res_ch.record_index;
			got.status_class   = res_ch.status_class;
			got.body_byte      = res_ch.body_byte;
			got.last_of_record = res_ch.last_of_record;
			got.last_of_batch  = res_ch.last_of_batch;
			results_seen++;
			kinds_seen[res_ch.kind]++;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 20)
					$display("%0t: unexpected result kind=%0d idx=%0d cls=%0d byte=%02h",
						$time, got.kind, got.record_index, got.status_class, got.body_byte);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 20)
						$display({"%0t: exp kind=%0d idx=%0d cls=%0d byte=%02h lrec=%0b ",
							"lbat=%0b, got kind=%0d idx=%0d cls=%0d byte=%02h lrec=%0b lbat=%0b"},
							$time, want.kind, want.record_index, want.status_class,
							want.body_byte, want.last_of_record, want.last_of_batch,
							got.kind, got.record_index, got.status_class, got.body_byte,
							got.last_of_record, got.last_of_batch);
				end
			end
		end
	end

	initial begin
		calm             = 1'b0;
		rx_ch.valid      = 1'b0;
		rx_ch.rx_byte    = '0;
		rx_ch.stream_end = 1'b0;
		arst_n           = 1'b0;
		clear_state();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_framed_batches();
		test_back_to_back();
		test_cut_and_noise();

		rx_ch.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d reply bytes and closes sent, %0d results checked", bytes_sent,
			results_seen);
		$display("body bytes %0d, empty records %0d, empty batches %0d, truncations %0d",
			kinds_seen[KIND_BODY], kinds_seen[KIND_EMPTY_REC], kinds_seen[KIND_EMPTY_BATCH],
			kinds_seen[KIND_TRUNC]);
		if (mismatches == 0) begin
			$display("reply_batch_deframer_top: match");
		end else begin
			$display("reply_batch_deframer_top: mismatch");
		end
		$finish;
	end

endmodule
